>>> sv/tpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the threshold promote cache.
// Used by tpc_cell and threshold_promote_cache; depends on nothing.
package tpc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CAP_W      = 5;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROMOTE_LIMIT = 4'd1;

    localparam logic [CAP_W-1:0]   CAPACITY_RST = 5'd16;
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 16'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // Per-cell update command.
    typedef struct packed {
        logic shift;   // take the neighbor's entry
        logic bump;    // overwrite own count in place
    } t_cell_ctl;

endpackage

>>> sv/threshold_promote_cache.sv
`timescale 1ns / 1ps
// Threshold promote cache: an ordered list of up to capacity keys with hit
// counters, held in a row of tpc_cell slots with the front at slot 0. A lookup
// goes through accept, compare across all cells and update of the row in
// turn; its result is registered at the update, which waits while the result
// register is stalled, and no new key is accepted until that update is done. A
// miss inserts the key at the front with count 1; a hit on an entry whose count
// equals promote_limit moves it to the front. When the list exceeds capacity the
// back entry is dropped and reported in the same result.
module threshold_promote_cache #(
    parameter int MAX_ENTRIES = tpc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_WIDTH   = tpc_pkg::KEY_WIDTH_DEF,
    parameter int COUNT_WIDTH = tpc_pkg::COUNT_WIDTH_DEF,
    localparam int NW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [KEY_WIDTH-1:0]              i_lookup_key,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic [COUNT_WIDTH-1:0]            o_count_after,
    output logic                              o_promoted,
    output logic                              o_evicted,
    output logic [KEY_WIDTH-1:0]              o_evicted_key,
    output logic [COUNT_WIDTH-1:0]            o_evicted_count,
    output logic [NW-1:0]                     o_occupancy,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tpc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int EW   = (tpc_pkg::CAP_W > NW + 1) ? tpc_pkg::CAP_W : NW + 1;
    localparam int CMPW = (COUNT_WIDTH > tpc_pkg::LIMIT_W) ? COUNT_WIDTH
                                                           : tpc_pkg::LIMIT_W;

    tpc_pkg::t_state r_state, n_state;

    logic [tpc_pkg::CAP_W-1:0]   r_capacity;
    logic [tpc_pkg::LIMIT_W-1:0] r_limit;
    logic [NW-1:0]               r_n;
    logic [KEY_WIDTH-1:0]        r_key;
    logic [MAX_ENTRIES-1:0]      r_match;
    logic [MAX_ENTRIES-1:0]      r_tail;
    logic                        r_hit;
    logic [COUNT_WIDTH-1:0]      r_hcount;

    logic                        r_out_valid;
    logic                        r_o_hit;
    logic [COUNT_WIDTH-1:0]      r_o_count;
    logic                        r_o_promoted;
    logic                        r_o_evicted;
    logic [KEY_WIDTH-1:0]        r_o_ev_key;
    logic [COUNT_WIDTH-1:0]      r_o_ev_count;
    logic [NW-1:0]               r_o_occ;

    logic in_take, cmp_en, upd_go;

    logic [MAX_ENTRIES-1:0]  w_match;
    logic [MAX_ENTRIES:0]    w_tail;
    logic [KEY_WIDTH-1:0]    w_key   [MAX_ENTRIES];
    logic [COUNT_WIDTH-1:0]  w_cnt   [MAX_ENTRIES];
    logic [KEY_WIDTH-1:0]    w_nkey  [MAX_ENTRIES];
    logic [COUNT_WIDTH-1:0]  w_ncnt  [MAX_ENTRIES];
    tpc_pkg::t_cell_ctl      w_ctl   [MAX_ENTRIES];

    logic [COUNT_WIDTH-1:0]  sel_count;
    logic                    promote;
    logic [COUNT_WIDTH-1:0]  count_after;
    logic [EW-1:0]           cap_eff;
    logic [EW-1:0]           new_n;
    logic [EW-1:0]           ev_idx;
    logic                    evict;
    logic [KEY_WIDTH-1:0]    ev_key;
    logic [COUNT_WIDTH-1:0]  ev_count;
    logic [NW-1:0]           n_n;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= tpc_pkg::CAPACITY_RST;
            r_limit    <= tpc_pkg::LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tpc_pkg::REG_CAPACITY:      r_capacity <= i_cfg_data[tpc_pkg::CAP_W-1:0];
                tpc_pkg::REG_PROMOTE_LIMIT: r_limit    <= i_cfg_data[tpc_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpc_pkg::S_IDLE: if (i_in_valid) n_state = tpc_pkg::S_CMP;
            tpc_pkg::S_CMP:  n_state = tpc_pkg::S_UPD;
            tpc_pkg::S_UPD:  if (!(r_out_valid && i_out_stall)) n_state = tpc_pkg::S_IDLE;
            default:         n_state = tpc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != tpc_pkg::S_IDLE);
        in_take    = (r_state == tpc_pkg::S_IDLE) && i_in_valid;
        cmp_en     = (r_state == tpc_pkg::S_CMP);
        upd_go     = (r_state == tpc_pkg::S_UPD) && !(r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_key <= i_lookup_key;
        end
    end

    // Row of cells. Slot 0 takes the looked-up key from the front.
    assign w_tail[MAX_ENTRIES] = 1'b0;

    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        logic live, in_range;
        logic [KEY_WIDTH-1:0]   prev_key;
        logic [COUNT_WIDTH-1:0] prev_count;

        assign live     = {1'b0, r_n} > (NW + 1)'(gi);
        assign in_range = {1'b0, r_n} >= (NW + 1)'(gi);

        if (gi == 0) begin : g_front
            assign prev_key   = r_key;
            assign prev_count = count_after;
        end else begin : g_inner
            assign prev_key   = w_key[gi-1];
            assign prev_count = w_cnt[gi-1];
        end

        assign w_ctl[gi] = '{
            shift: upd_go && promote && (r_hit ? r_tail[gi] : in_range),
            bump:  upd_go && r_hit && !promote && r_match[gi]
        };

        tpc_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[gi]),
            .i_live       (live),
            .i_lookup_key (r_key),
            .i_prev_key   (prev_key),
            .i_prev_count (prev_count),
            .i_new_count  (count_after),
            .i_tail       (w_tail[gi+1]),
            .o_match      (w_match[gi]),
            .o_tail       (w_tail[gi]),
            .o_key        (w_key[gi]),
            .o_count      (w_cnt[gi]),
            .o_next_key   (w_nkey[gi]),
            .o_next_count (w_ncnt[gi])
        );
    end

    // Compare pass: capture which slot holds the key and its counter.
    always_comb begin
        sel_count = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            sel_count = sel_count | (w_match[i] ? w_cnt[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmp_en) begin
            r_match  <= w_match;
            r_tail   <= w_tail[MAX_ENTRIES-1:0];
            r_hit    <= |w_match;
            r_hcount <= sel_count;
        end
    end

    // Update pass.
    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = EW'(1);
        end else if (EW'(r_capacity) > EW'(MAX_ENTRIES)) begin
            cap_eff = EW'(MAX_ENTRIES);
        end else begin
            cap_eff = EW'(r_capacity);
        end

        promote     = !r_hit || (CMPW'(r_hcount) == CMPW'(r_limit));
        count_after = !r_hit ? COUNT_WIDTH'(1)
                    : ((&r_hcount) ? r_hcount : r_hcount + COUNT_WIDTH'(1));

        new_n  = EW'(r_n) + EW'(!r_hit);
        evict  = new_n > cap_eff;
        ev_idx = new_n - EW'(1);

        // The back entry after the update; on a full miss it is the one
        // pushed out of the last slot.
        ev_key   = '0;
        ev_count = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (evict && (ev_idx == EW'(i))) begin
                ev_key   = ev_key | w_nkey[i];
                ev_count = ev_count | w_ncnt[i];
            end
        end
        if (evict && (ev_idx == EW'(MAX_ENTRIES))) begin
            ev_key   = ev_key | w_key[MAX_ENTRIES-1];
            ev_count = ev_count | w_cnt[MAX_ENTRIES-1];
        end

        n_n = evict ? NW'(ev_idx) : NW'(new_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (upd_go) begin
            r_n <= n_n;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_o_hit      <= r_hit;
            r_o_count    <= count_after;
            r_o_promoted <= promote;
            r_o_evicted  <= evict;
            r_o_ev_key   <= ev_key;
            r_o_ev_count <= ev_count;
            r_o_occ      <= n_n;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_count_after   = r_o_count;
    assign o_promoted      = r_o_promoted;
    assign o_evicted       = r_o_evicted;
    assign o_evicted_key   = r_o_ev_key;
    assign o_evicted_count = r_o_ev_count;
    assign o_occupancy     = r_o_occ;

    // Keys in the list are unique, so at most one cell can match.
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpc_pkg::S_UPD) |-> $onehot0(r_match))
        else $error("more than one cell matched the lookup key");

    a_hit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpc_pkg::S_UPD) |-> (r_hit == (|r_match)))
        else $error("hit flag disagrees with the captured match vector");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_n} <= (NW + 1)'(MAX_ENTRIES))
        else $error("entry count exceeds the number of cells");

    a_miss_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_promoted && (o_count_after == COUNT_WIDTH'(1))))
        else $error("miss transaction did not insert with count one");

endmodule

>>> sv/tpc_cell.sv
`timescale 1ns / 1ps
// One slot of the cache list: key and hit counter, compare against the
// lookup key, and shift from the front-side neighbor. Depends on tpc_pkg.
module tpc_cell #(
    parameter int KEY_WIDTH   = tpc_pkg::KEY_WIDTH_DEF,
    parameter int COUNT_WIDTH = tpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  tpc_pkg::t_cell_ctl     i_ctl,
    input  logic                   i_live,
    input  logic [KEY_WIDTH-1:0]   i_lookup_key,
    input  logic [KEY_WIDTH-1:0]   i_prev_key,
    input  logic [COUNT_WIDTH-1:0] i_prev_count,
    input  logic [COUNT_WIDTH-1:0] i_new_count,
    input  logic                   i_tail,
    output logic                   o_match,
    output logic                   o_tail,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic [KEY_WIDTH-1:0]   o_next_key,
    output logic [COUNT_WIDTH-1:0] o_next_count
);

    logic [KEY_WIDTH-1:0]   r_key;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [KEY_WIDTH-1:0]   n_key;
    logic [COUNT_WIDTH-1:0] n_count;

    always_comb begin
        n_key   = r_key;
        n_count = r_count;
        if (i_ctl.shift) begin
            n_key   = i_prev_key;
            n_count = i_prev_count;
        end else if (i_ctl.bump) begin
            n_count = i_new_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_count <= n_count;
    end

    assign o_match      = i_live && (r_key == i_lookup_key);
    // True when this slot or any slot behind it holds the key.
    assign o_tail       = o_match | i_tail;
    assign o_key        = r_key;
    assign o_count      = r_count;
    assign o_next_key   = n_key;
    assign o_next_count = n_count;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for threshold_promote_cache: a directed table and
// random key streams over several register settings.
// Depends on tpc_pkg and threshold_promote_cache; every result is checked in order.
module tb;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int IDLE_PCT        = 32;
    localparam int HOLD_CYCLES     = 200;
    localparam int SLOTS           = 16;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int PHASES          = 9;
    localparam int DIR_ROWS        = 30;
    localparam int MAX_REPORTS     = 10;

    localparam logic [15:0] COUNT_SAT = 16'hFFFF;
    localparam logic [tpc_pkg::CFG_IDX_W-1:0] REG_CAP      = tpc_pkg::REG_CAPACITY;
    localparam logic [tpc_pkg::CFG_IDX_W-1:0] REG_LIM      = tpc_pkg::REG_PROMOTE_LIMIT;
    localparam logic [tpc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 4'd2;
    localparam logic [tpc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

    localparam logic [tpc_pkg::CAP_W-1:0] PHASE_CAP [PHASES] =
        '{16, 1, 5, 0, 8, 31, 3, 17, 16};
    localparam logic [tpc_pkg::LIMIT_W-1:0] PHASE_LIMIT [PHASES] =
        '{4, 1, 2, 3, 0, 65535, 1, 2, 5};

    typedef struct packed {
        logic        hit;
        logic [15:0] count_after;
        logic        promoted;
        logic        evicted;
        logic [31:0] evicted_key;
        logic [15:0] evicted_count;
        logic [4:0]  occupancy;
    } t_access_result;

    typedef enum logic {ROW_LOOKUP, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [31:0]                    key;
        logic [tpc_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [tpc_pkg::CFG_DATA_W-1:0] reg_data;
        logic                           pinned;
        t_access_result                 pin_result;
    } t_stim_row;

    // Rows with pinned set carry a result that is obvious from the list contents.
    t_stim_row dir_table [DIR_ROWS] = '{
        '{ROW_LOOKUP, 32'h0000_0000, REG_CAP, 16'd0, 1'b1, '{0, 1, 1, 0, 0, 0, 1}},
        '{ROW_LOOKUP, 32'hFFFF_FFFF, REG_CAP, 16'd0, 1'b1, '{0, 1, 1, 0, 0, 0, 2}},
        '{ROW_LOOKUP, 32'h0000_0000, REG_CAP, 16'd0, 1'b1, '{1, 2, 0, 0, 0, 0, 2}},
        '{ROW_LOOKUP, 32'h0000_0000, REG_CAP, 16'd0, 1'b1, '{1, 3, 0, 0, 0, 0, 2}},
        '{ROW_LOOKUP, 32'h0000_0000, REG_CAP, 16'd0, 1'b1, '{1, 4, 0, 0, 0, 0, 2}},
        '{ROW_LOOKUP, 32'h0000_0000, REG_CAP, 16'd0, 1'b1, '{1, 5, 1, 0, 0, 0, 2}},
        '{ROW_LOOKUP, 32'h0000_0000, REG_CAP, 16'd0, 1'b1, '{1, 6, 0, 0, 0, 0, 2}},
        '{ROW_LOOKUP, 32'hA5A5_A5A5, REG_CAP, 16'd0, 1'b0, '0},
        '{ROW_LOOKUP, 32'h5A5A_5A5A, REG_CAP, 16'd0, 1'b0, '0},
        '{ROW_WRITE,  32'h0000_0000, REG_CAP, 16'd2, 1'b0, '0},
        '{ROW_LOOKUP, 32'h1234_5678, REG_CAP, 16'd0, 1'b0, '0},
        '{ROW_LOOKUP, 32'h0000_0000, REG_CAP, 16'd0, 1'b0, '0},
        '{ROW_LOOKUP, 32'h5A5A_5A5A, REG_CAP, 16'd0, 1'b0, '0},
        '{ROW_WRITE,  32'h0000_0000, REG_CAP, 16'd0, 1'b0, '0},
        '{ROW_LOOKUP, 32'h8000_0000, REG_CAP, 16'd0, 1'b0, '0},
        '{ROW_LOOKUP, 32'h8000_0000, REG_CAP, 16'd0, 1'b0, '0},
        '{ROW_LOOKUP, 32'h0000_0001, REG_CAP, 16'd0, 1'b1,
          '{0, 1, 1, 1, 32'h8000_0000, 2, 1}},
        '{ROW_WRITE,  32'h0000_0000, REG_CAP, 16'd31, 1'b0, '0},
        '{ROW_WRITE,  32'h0000_0000, REG_LIM, 16'd0, 1'b0, '0},
        '{ROW_WRITE,  32'h0000_0000, REG_SPARE_HI, 16'hFFFF, 1'b0, '0},
        '{ROW_WRITE,  32'h0000_0000, REG_SPARE_LO, 16'd1, 1'b0, '0},
        '{ROW_LOOKUP, 32'h0000_0001, REG_CAP, 16'd0, 1'b1, '{1, 2, 0, 0, 0, 0, 1}},
        '{ROW_LOOKUP, 32'hFFFF_FFFF, REG_CAP, 16'd0, 1'b1, '{0, 1, 1, 0, 0, 0, 2}},
        '{ROW_LOOKUP, 32'h0000_0001, REG_CAP, 16'd0, 1'b1, '{1, 3, 0, 0, 0, 0, 2}},
        '{ROW_WRITE,  32'h0000_0000, REG_LIM, 16'd1, 1'b0, '0},
        '{ROW_LOOKUP, 32'hFFFF_FFFF, REG_CAP, 16'd0, 1'b1, '{1, 2, 1, 0, 0, 0, 2}},
        '{ROW_LOOKUP, 32'h0000_0001, REG_CAP, 16'd0, 1'b1, '{1, 4, 0, 0, 0, 0, 2}},
        '{ROW_WRITE,  32'h0000_0000, REG_CAP, 16'hFFF0, 1'b0, '0},
        '{ROW_WRITE,  32'h0000_0000, REG_LIM, 16'hFFFF, 1'b0, '0},
        '{ROW_LOOKUP, 32'hFFFF_0000, REG_CAP, 16'd0, 1'b0, '0}
    };

    logic                           i_clk;
    logic                           i_rst_n      = 1'b0;
    logic                           i_in_valid   = 1'b0;
    logic [31:0]                    i_lookup_key = '0;
    logic                           i_out_stall  = 1'b0;
    logic                           i_cfg_valid  = 1'b0;
    logic [tpc_pkg::CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [tpc_pkg::CFG_DATA_W-1:0] i_cfg_data   = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_hit;
    logic [15:0] o_count_after;
    logic        o_promoted;
    logic        o_evicted;
    logic [31:0] o_evicted_key;
    logic [15:0] o_evicted_count;
    logic [4:0]  o_occupancy;
    logic        o_cfg_ready;

    // Typed expectation that travels with the key it belongs to.
    logic           drv_pinned     = 1'b0;
    t_access_result drv_pin_result = '0;

    // Predictor copy of the list and the registers.
    logic [31:0]  mdl_keys   [SLOTS+1];
    logic [15:0]  mdl_counts [SLOTS+1];
    int unsigned  mdl_held     = 0;
    logic [tpc_pkg::CAP_W-1:0]   mdl_capacity = tpc_pkg::CAPACITY_RST;
    logic [tpc_pkg::LIMIT_W-1:0] mdl_limit    = tpc_pkg::LIMIT_RST;

    t_access_result pending_results [$];

    int          idle_pct        = IDLE_PCT;
    int unsigned hold_req        = 0;
    int unsigned hold_seen       = 0;
    int unsigned hold_left       = 0;
    int unsigned keys_sent       = 0;
    int unsigned results_seen    = 0;
    int unsigned hits_seen       = 0;
    int unsigned promotions_seen = 0;
    int unsigned evictions_seen  = 0;
    int unsigned writes_seen     = 0;
    int unsigned fail_count      = 0;
    int unsigned cycle_count     = 0;

    threshold_promote_cache i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_lookup_key    (i_lookup_key),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_count_after   (o_count_after),
        .o_promoted      (o_promoted),
        .o_evicted       (o_evicted),
        .o_evicted_key   (o_evicted_key),
        .o_evicted_count (o_evicted_count),
        .o_occupancy     (o_occupancy),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Applies one lookup to the predictor list and returns what the block should report.
    function automatic t_access_result predict_access(input logic [31:0] key);
        t_access_result r;
        int unsigned    n, cap, slot, upto, i;
        logic           found, move;
        logic [15:0]    c;
        r     = '0;
        n     = mdl_held;
        found = 1'b0;
        slot  = 0;
        if (mdl_capacity == 0)
            cap = 1;
        else if (mdl_capacity > SLOTS)
            cap = SLOTS;
        else
            cap = mdl_capacity;
        for (i = 0; i < n; i++) begin
            if (!found && mdl_keys[i] == key) begin
                found = 1'b1;
                slot  = i;
            end
        end
        move = 1'b1;
        upto = n;
        if (found) begin
            c             = mdl_counts[slot];
            r.hit         = 1'b1;
            r.count_after = (c == COUNT_SAT) ? c : c + 16'd1;
            if (c == mdl_limit) begin
                upto = slot;
            end else begin
                move             = 1'b0;
                mdl_counts[slot] = r.count_after;
            end
        end else begin
            r.count_after = 16'd1;
            n++;
        end
        if (move) begin
            for (i = upto; i > 0; i--) begin
                mdl_keys[i]   = mdl_keys[i-1];
                mdl_counts[i] = mdl_counts[i-1];
            end
            mdl_keys[0]   = key;
            mdl_counts[0] = r.count_after;
            r.promoted    = 1'b1;
        end
        // Only one back entry goes per access, even when capacity was cut further.
        if (n > cap) begin
            r.evicted       = 1'b1;
            r.evicted_key   = mdl_keys[n-1];
            r.evicted_count = mdl_counts[n-1];
            n--;
        end
        mdl_held    = n;
        r.occupancy = n[4:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_access_result got, want;
        logic           bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_hit, o_count_after, o_promoted, o_evicted, o_evicted_key,
                    o_evicted_count, o_occupancy};
            results_seen++;
            hits_seen       += got.hit;
            promotions_seen += got.promoted;
            evictions_seen  += got.evicted;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("Result %0d arrived with nothing outstanding", results_seen);
            end else begin
                want = pending_results.pop_front();
                bad  = (got.hit !== want.hit) || (got.count_after !== want.count_after) ||
                       (got.promoted !== want.promoted) || (got.evicted !== want.evicted) ||
                       (got.evicted_key !== want.evicted_key) ||
                       (got.evicted_count !== want.evicted_count) ||
                       (got.occupancy !== want.occupancy);
                if (bad) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("Mismatch on result %0d:", results_seen);
                        $display("  exp hit=%0b cnt=%0d prom=%0b ev=%0b key=%h evcnt=%0d occ=%0d",
                                 want.hit, want.count_after, want.promoted, want.evicted,
                                 want.evicted_key, want.evicted_count, want.occupancy);
                        $display("  got hit=%0b cnt=%0d prom=%0b ev=%0b key=%h evcnt=%0d occ=%0d",
                                 got.hit, got.count_after, got.promoted, got.evicted,
                                 got.evicted_key, got.evicted_count, got.occupancy);
                    end
                end
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            want = predict_access(i_lookup_key);
            pending_results.push_back(drv_pinned ? drv_pin_result : want);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            writes_seen++;
            case (i_cfg_index)
                REG_CAP: begin
                    mdl_capacity = i_cfg_data[tpc_pkg::CAP_W-1:0];
                end
                REG_LIM: begin
                    mdl_limit = i_cfg_data[tpc_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Result side: random stalls, or a counted hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_key(input logic [31:0] key, input logic pinned,
                            input t_access_result pin_result);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_lookup_key   <= key;
        drv_pinned     <= pinned;
        drv_pin_result <= pin_result;
        do @(posedge i_clk); while (o_in_stall);
        keys_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (results_seen < keys_sent)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tpc_pkg::CFG_IDX_W-1:0] index,
                             input logic [tpc_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    initial begin : stimulus
        logic [31:0] key;
        logic [31:0] key_pool [$];
        int          p, n, cap_eff;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_WRITE)
                write_reg(dir_table[r].reg_index, dir_table[r].reg_data);
            else
                send_key(dir_table[r].key, dir_table[r].pinned, dir_table[r].pin_result);
        end

        // Keys mostly come from a small pool so that hits, promotions and evictions mix.
        for (p = 0; p < PHASES; p++) begin
            write_reg(REG_CAP, tpc_pkg::CFG_DATA_W'(PHASE_CAP[p]));
            write_reg(REG_LIM, tpc_pkg::CFG_DATA_W'(PHASE_LIMIT[p]));
            if (PHASE_CAP[p] == 0)
                cap_eff = 1;
            else if (PHASE_CAP[p] > SLOTS)
                cap_eff = SLOTS;
            else
                cap_eff = PHASE_CAP[p];
            idle_pct = (p == 2) ? 0 : IDLE_PCT;
            key_pool.delete();
            repeat ($urandom_range(cap_eff + 6, 2)) key_pool.push_back($urandom);
            if (p == 4)
                hold_req++;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 6 && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                if ($urandom_range(99) < 75)
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                else
                    key = $urandom;
                send_key(key, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d lookups: %0d hits, %0d promotions, %0d evictions.",
                 results_seen, hits_seen, promotions_seen, evictions_seen);
        $display("Register writes: %0d over %0d random settings; failures: %0d.",
                 writes_seen, PHASES, fail_count + pending_results.size());
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
